// File: hdl/selective_repeat_sender_window_top_assert.svh
// Assertion macros for the selective-repeat sender window checker.
// Included by the checker file only; needs nothing else.
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_TOP_ASSERT_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRSW_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SRSW_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/srsw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the selective-repeat sender window.
// Used by the top level and by the port checker; depends on nothing.
package srsw_pkg;

    localparam int MAX_PACKETS_DEF = 4096;
    localparam int MAX_WINDOW_DEF  = 32;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 13;
    localparam int WINDOW_W    = 6;
    localparam int TOTAL_W     = 13;
    localparam int OPCODE_W    = 2;
    localparam int ACK_W       = 16;
    localparam int KIND_W      = 2;
    localparam int INDEX_W     = 12;
    localparam int VERDICT_W   = 3;
    localparam int START_W     = 13;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 6'd5;
    localparam logic [TOTAL_W-1:0]  TOTAL_RESET  = 13'd1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WINDOW_LENGTH = 1'b0,
        CFG_PACKET_TOTAL  = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_NOT_SENT = 2'd0,
        ST_AWAIT    = 2'd1,
        ST_ACKED    = 2'd2
    } status_t;

    typedef enum logic [OPCODE_W-1:0] {
        OP_SEND    = 2'd0,
        OP_ACK     = 2'd1,
        OP_TIMEOUT = 2'd2,
        OP_NONE    = 2'd3
    } opcode_t;

    typedef enum logic [KIND_W-1:0] {
        RK_SEND    = 2'd0,
        RK_ACK     = 2'd1,
        RK_TIMEOUT = 2'd2,
        RK_NOTHING = 2'd3
    } kind_t;

    typedef enum logic [VERDICT_W-1:0] {
        V_BASE  = 3'd0,
        V_BUF   = 3'd1,
        V_LOW   = 3'd2,
        V_NEVER = 3'd3,
        V_HIGH  = 3'd4
    } verdict_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RESCAN,
        S_WALK,
        S_ACK,
        S_SLIDE,
        S_FINISH
    } state_t;

endpackage

// File: hdl/selective_repeat_sender_window_top.sv
`timescale 1ns / 1ps
// Selective-repeat sender window: per-packet status memory and window base.
// Depends on srsw_pkg.
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  s_       | s_valid / s_ready   | s_opcode, s_ack_number
//  m_       | m_valid / m_ready   | m_result_kind, m_send_index, m_ack_verdict,
//           |                     | m_window_start, m_all_acked, m_last
//  cfg_     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Send and timeout words walk the window from the base (at most the window length),
// reading one status entry per cycle from the status memory, which has one read
// and one write port, the next read overlapping the update; a full result
// register holds a send walk at a further unsent entry, and the finish step,
// until the word is taken. Acks ruled too low or too high go to the finish
// step; other acks read their entry, and an ack of the base then slides the
// base over the acked entries after it, up to the total. After reset a clearing
// pass writes MAX_PACKETS entries, one per cycle, with no word accepted. A
// packet_total write recounts the unacked entries from base to total, one per cycle.
module selective_repeat_sender_window_top #(
    parameter int MAX_PACKETS = srsw_pkg::MAX_PACKETS_DEF,
    parameter int MAX_WINDOW  = srsw_pkg::MAX_WINDOW_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [srsw_pkg::OPCODE_W-1:0]     s_opcode,
    input  logic [srsw_pkg::ACK_W-1:0]        s_ack_number,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [srsw_pkg::KIND_W-1:0]       m_result_kind,
    output logic [srsw_pkg::INDEX_W-1:0]      m_send_index,
    output logic [srsw_pkg::VERDICT_W-1:0]    m_ack_verdict,
    output logic [srsw_pkg::START_W-1:0]      m_window_start,
    output logic                              m_all_acked,
    output logic                              m_last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [srsw_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [srsw_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int AW = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
    localparam int BW = $clog2(MAX_PACKETS + 1);
    localparam int EW = $clog2(MAX_PACKETS + MAX_WINDOW + 1);
    localparam int CW = (EW > srsw_pkg::ACK_W) ? EW : srsw_pkg::ACK_W;
    localparam int IW = (AW > srsw_pkg::INDEX_W) ? AW : srsw_pkg::INDEX_W;
    localparam int XW = (BW > srsw_pkg::START_W) ? BW : srsw_pkg::START_W;
    localparam logic [AW-1:0] LAST_ENTRY = AW'(MAX_PACKETS - 1);

    // Status memory.
    logic [1:0]    status_mem [MAX_PACKETS];
    logic [1:0]    rd_data_reg;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [1:0]    wr_data;

    srsw_pkg::state_t            state_reg, state_next;
    logic [AW-1:0]               clr_reg, clr_next;
    logic [CW-1:0]               cur_reg, cur_next;
    logic [CW-1:0]               limit_reg, limit_next;
    logic [CW-1:0]               ack_reg, ack_next;
    srsw_pkg::opcode_t           op_reg, op_next;
    srsw_pkg::verdict_t          verdict_reg, verdict_next;
    logic [BW-1:0]               base_reg, base_next;
    logic [BW-1:0]               pending_reg, pending_next;
    logic [BW-1:0]               cnt_reg, cnt_next;
    logic                        held_valid_reg, held_valid_next;
    logic [AW-1:0]               held_idx_reg, held_idx_next;
    logic [srsw_pkg::WINDOW_W-1:0] window_reg, window_next;
    logic [srsw_pkg::TOTAL_W-1:0]  total_reg, total_next;
    logic                        rescan_req_reg, rescan_req_next;

    logic                        m_valid_reg, m_valid_next;
    srsw_pkg::kind_t             m_kind_reg, m_kind_next;
    logic [srsw_pkg::INDEX_W-1:0]   m_idx_reg, m_idx_next;
    srsw_pkg::verdict_t          m_verdict_reg, m_verdict_next;
    logic [srsw_pkg::START_W-1:0]   m_start_reg, m_start_next;
    logic                        m_all_reg, m_all_next;
    logic                        m_last_reg, m_last_next;

    logic                        push;
    srsw_pkg::kind_t             push_kind;
    logic [AW-1:0]               push_idx;
    srsw_pkg::verdict_t          push_verdict;
    logic                        push_last;

    logic                        out_free;
    logic [CW-1:0]               base_x, n_eff, w_eff, end_x, tot_x, win_x, ack_x;
    logic [CW-1:0]               cur_inc, base_inc;
    logic [BW-1:0]               cnt_inc;
    logic [IW-1:0]               push_idx_x;
    logic [XW-1:0]               base_out_x;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            status_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= status_mem[rd_addr];
        end
    end

    // Effective window and total, clamped into their legal ranges.
    always_comb begin
        tot_x = CW'(total_reg);
        win_x = CW'(window_reg);
        if (tot_x == '0) begin
            n_eff = CW'(1);
        end else if (tot_x > CW'(MAX_PACKETS)) begin
            n_eff = CW'(MAX_PACKETS);
        end else begin
            n_eff = tot_x;
        end
        if (win_x == '0) begin
            w_eff = CW'(1);
        end else if (win_x > CW'(MAX_WINDOW)) begin
            w_eff = CW'(MAX_WINDOW);
        end else begin
            w_eff = win_x;
        end
    end

    assign base_x   = CW'(base_reg);
    assign end_x    = base_x + w_eff;
    assign ack_x    = CW'(s_ack_number);
    assign cur_inc  = cur_reg + CW'(1);
    assign base_inc = base_x + CW'(1);
    assign cnt_inc  = cnt_reg + ((rd_data_reg != srsw_pkg::ST_ACKED) ? BW'(1) : BW'(0));
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= srsw_pkg::S_CLEAR;
            clr_reg        <= '0;
            base_reg       <= '0;
            pending_reg    <= BW'(1);
            held_valid_reg <= 1'b0;
            window_reg     <= srsw_pkg::WINDOW_RESET;
            total_reg      <= srsw_pkg::TOTAL_RESET;
            rescan_req_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            base_reg       <= base_next;
            pending_reg    <= pending_next;
            held_valid_reg <= held_valid_next;
            window_reg     <= window_next;
            total_reg      <= total_next;
            rescan_req_reg <= rescan_req_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg       <= cur_next;
        limit_reg     <= limit_next;
        ack_reg       <= ack_next;
        op_reg        <= op_next;
        verdict_reg   <= verdict_next;
        cnt_reg       <= cnt_next;
        held_idx_reg  <= held_idx_next;
        m_kind_reg    <= m_kind_next;
        m_idx_reg     <= m_idx_next;
        m_verdict_reg <= m_verdict_next;
        m_start_reg   <= m_start_next;
        m_all_reg     <= m_all_next;
        m_last_reg    <= m_last_next;
    end

    assign s_ready   = (state_reg == srsw_pkg::S_IDLE) && !rescan_req_reg;
    assign cfg_ready = ((state_reg == srsw_pkg::S_IDLE) && !rescan_req_reg)
                       || (state_reg == srsw_pkg::S_CLEAR);

    always_comb begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        cur_next        = cur_reg;
        limit_next      = limit_reg;
        ack_next        = ack_reg;
        op_next         = op_reg;
        verdict_next    = verdict_reg;
        base_next       = base_reg;
        pending_next    = pending_reg;
        cnt_next        = cnt_reg;
        held_valid_next = held_valid_reg;
        held_idx_next   = held_idx_reg;
        window_next     = window_reg;
        total_next      = total_reg;
        rescan_req_next = rescan_req_reg;

        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = srsw_pkg::ST_NOT_SENT;

        push         = 1'b0;
        push_kind    = srsw_pkg::RK_NOTHING;
        push_idx     = '0;
        push_verdict = srsw_pkg::V_BASE;
        push_last    = 1'b1;

        unique case (state_reg)
            srsw_pkg::S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                if (clr_reg == LAST_ENTRY) begin
                    state_next = srsw_pkg::S_IDLE;
                end else begin
                    clr_next = clr_reg + AW'(1);
                end
            end

            srsw_pkg::S_IDLE: begin
                if (rescan_req_reg) begin
                    rescan_req_next = 1'b0;
                    if (base_x >= n_eff) begin
                        pending_next = '0;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = base_x[AW-1:0];
                        cur_next   = base_x;
                        cnt_next   = '0;
                        state_next = srsw_pkg::S_RESCAN;
                    end
                end else if (s_valid) begin
                    op_next    = srsw_pkg::opcode_t'(s_opcode);
                    limit_next = (end_x < n_eff) ? end_x : n_eff;
                    ack_next   = ack_x;
                    unique case (srsw_pkg::opcode_t'(s_opcode))
                        srsw_pkg::OP_SEND, srsw_pkg::OP_TIMEOUT: begin
                            if (base_x < end_x && base_x < n_eff) begin
                                rd_en      = 1'b1;
                                rd_addr    = base_x[AW-1:0];
                                cur_next   = base_x;
                                state_next = srsw_pkg::S_WALK;
                            end else begin
                                state_next = srsw_pkg::S_FINISH;
                            end
                        end
                        srsw_pkg::OP_ACK: begin
                            if (ack_x < base_x) begin
                                verdict_next = srsw_pkg::V_LOW;
                                state_next   = srsw_pkg::S_FINISH;
                            end else if (ack_x >= n_eff || ack_x >= end_x) begin
                                verdict_next = srsw_pkg::V_HIGH;
                                state_next   = srsw_pkg::S_FINISH;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = ack_x[AW-1:0];
                                state_next = srsw_pkg::S_ACK;
                            end
                        end
                        srsw_pkg::OP_NONE: begin
                            state_next = srsw_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            srsw_pkg::S_RESCAN: begin
                if (cur_inc < n_eff) begin
                    rd_en    = 1'b1;
                    rd_addr  = cur_inc[AW-1:0];
                    cur_next = cur_inc;
                    cnt_next = cnt_inc;
                end else begin
                    pending_next = cnt_inc;
                    state_next   = srsw_pkg::S_IDLE;
                end
            end

            srsw_pkg::S_WALK: begin
                if (op_reg == srsw_pkg::OP_SEND) begin
                    // A found entry waits in the hold register until the next
                    // one shows up, so that the final word can carry last.
                    if (rd_data_reg == srsw_pkg::ST_NOT_SENT && held_valid_reg
                        && !out_free) begin
                        state_next = srsw_pkg::S_WALK;
                    end else begin
                        if (rd_data_reg == srsw_pkg::ST_NOT_SENT) begin
                            wr_en   = 1'b1;
                            wr_addr = cur_reg[AW-1:0];
                            wr_data = srsw_pkg::ST_AWAIT;
                            if (held_valid_reg) begin
                                push      = 1'b1;
                                push_kind = srsw_pkg::RK_SEND;
                                push_idx  = held_idx_reg;
                                push_last = 1'b0;
                            end
                            held_valid_next = 1'b1;
                            held_idx_next   = cur_reg[AW-1:0];
                        end
                        if (cur_inc < limit_reg) begin
                            rd_en    = 1'b1;
                            rd_addr  = cur_inc[AW-1:0];
                            cur_next = cur_inc;
                        end else begin
                            state_next = srsw_pkg::S_FINISH;
                        end
                    end
                end else begin
                    if (rd_data_reg == srsw_pkg::ST_NOT_SENT) begin
                        state_next = srsw_pkg::S_FINISH;
                    end else begin
                        if (rd_data_reg == srsw_pkg::ST_AWAIT) begin
                            wr_en   = 1'b1;
                            wr_addr = cur_reg[AW-1:0];
                            wr_data = srsw_pkg::ST_NOT_SENT;
                        end
                        if (cur_inc < limit_reg) begin
                            rd_en    = 1'b1;
                            rd_addr  = cur_inc[AW-1:0];
                            cur_next = cur_inc;
                        end else begin
                            state_next = srsw_pkg::S_FINISH;
                        end
                    end
                end
            end

            srsw_pkg::S_ACK: begin
                if (ack_reg == base_x) begin
                    // The base is marked acked whatever it held before.
                    wr_en        = 1'b1;
                    wr_addr      = ack_reg[AW-1:0];
                    wr_data      = srsw_pkg::ST_ACKED;
                    verdict_next = srsw_pkg::V_BASE;
                    if (rd_data_reg != srsw_pkg::ST_ACKED) begin
                        pending_next = pending_reg - BW'(1);
                    end
                    base_next = base_inc[BW-1:0];
                    if (base_inc < n_eff) begin
                        rd_en      = 1'b1;
                        rd_addr    = base_inc[AW-1:0];
                        state_next = srsw_pkg::S_SLIDE;
                    end else begin
                        state_next = srsw_pkg::S_FINISH;
                    end
                end else if (rd_data_reg == srsw_pkg::ST_AWAIT) begin
                    wr_en        = 1'b1;
                    wr_addr      = ack_reg[AW-1:0];
                    wr_data      = srsw_pkg::ST_ACKED;
                    verdict_next = srsw_pkg::V_BUF;
                    pending_next = pending_reg - BW'(1);
                    state_next   = srsw_pkg::S_FINISH;
                end else begin
                    verdict_next = srsw_pkg::V_NEVER;
                    state_next   = srsw_pkg::S_FINISH;
                end
            end

            srsw_pkg::S_SLIDE: begin
                if (rd_data_reg == srsw_pkg::ST_ACKED) begin
                    base_next = base_inc[BW-1:0];
                    if (base_inc < n_eff) begin
                        rd_en   = 1'b1;
                        rd_addr = base_inc[AW-1:0];
                    end else begin
                        state_next = srsw_pkg::S_FINISH;
                    end
                end else begin
                    state_next = srsw_pkg::S_FINISH;
                end
            end

            srsw_pkg::S_FINISH: begin
                if (out_free) begin
                    push       = 1'b1;
                    push_last  = 1'b1;
                    state_next = srsw_pkg::S_IDLE;
                    case (op_reg)
                        srsw_pkg::OP_SEND: begin
                            if (held_valid_reg) begin
                                push_kind = srsw_pkg::RK_SEND;
                                push_idx  = held_idx_reg;
                            end else begin
                                push_kind = srsw_pkg::RK_NOTHING;
                            end
                        end
                        srsw_pkg::OP_ACK: begin
                            push_kind    = srsw_pkg::RK_ACK;
                            push_verdict = verdict_reg;
                        end
                        default: begin
                            push_kind = srsw_pkg::RK_TIMEOUT;
                        end
                    endcase
                    held_valid_next = 1'b0;
                end
            end

            default: begin
                state_next = srsw_pkg::S_IDLE;
            end
        endcase

        if (cfg_valid && cfg_ready) begin
            unique case (srsw_pkg::cfg_reg_t'(cfg_index))
                srsw_pkg::CFG_WINDOW_LENGTH: begin
                    window_next = cfg_data[srsw_pkg::WINDOW_W-1:0];
                end
                srsw_pkg::CFG_PACKET_TOTAL: begin
                    total_next      = cfg_data[srsw_pkg::TOTAL_W-1:0];
                    rescan_req_next = 1'b1;
                end
            endcase
        end
    end

    // Result register; the base and the unacked count are already final
    // whenever a word is loaded.
    assign push_idx_x = IW'(push_idx);
    assign base_out_x = XW'(base_reg);

    always_comb begin
        m_valid_next   = m_valid_reg;
        m_kind_next    = m_kind_reg;
        m_idx_next     = m_idx_reg;
        m_verdict_next = m_verdict_reg;
        m_start_next   = m_start_reg;
        m_all_next     = m_all_reg;
        m_last_next    = m_last_reg;
        if (push) begin
            m_valid_next   = 1'b1;
            m_kind_next    = push_kind;
            m_idx_next     = push_idx_x[srsw_pkg::INDEX_W-1:0];
            m_verdict_next = push_verdict;
            m_start_next   = base_out_x[srsw_pkg::START_W-1:0];
            m_all_next     = (pending_reg == '0);
            m_last_next    = push_last;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_kind  = m_kind_reg;
    assign m_send_index   = m_idx_reg;
    assign m_ack_verdict  = m_verdict_reg;
    assign m_window_start = m_start_reg;
    assign m_all_acked    = m_all_reg;
    assign m_last         = m_last_reg;

endmodule

// File: hdl/srsw_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the selective-repeat sender window, bound to the top.
// Depends on srsw_pkg and selective_repeat_sender_window_top_assert.svh.
`include "selective_repeat_sender_window_top_assert.svh"

module srsw_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [srsw_pkg::KIND_W-1:0]       m_result_kind,
    input logic [srsw_pkg::INDEX_W-1:0]      m_send_index,
    input logic [srsw_pkg::VERDICT_W-1:0]    m_ack_verdict,
    input logic [srsw_pkg::START_W-1:0]      m_window_start,
    input logic                              m_all_acked,
    input logic                              m_last
);

    localparam int OUT_W = 3 + srsw_pkg::KIND_W + srsw_pkg::INDEX_W + srsw_pkg::VERDICT_W
                           + srsw_pkg::START_W;

    logic             word_not_send;
    logic             word_not_ack;
    logic             out_stall;
    logic [OUT_W-1:0] out_word;

    assign word_not_send = m_valid && (m_result_kind != srsw_pkg::RK_SEND);
    assign word_not_ack  = m_valid && (m_result_kind != srsw_pkg::RK_ACK);
    assign out_stall     = m_valid && !m_ready;
    assign out_word      = {m_valid, m_result_kind, m_send_index, m_ack_verdict,
                            m_window_start, m_all_acked, m_last};

    // A stalled result word stays valid and keeps its payload.
    `SRSW_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stall, $stable(out_word), "stalled word changed")

    // Only send requests carry a packet index.
    `SRSW_ASSERT_NOW(a_idx_zero, aclk, aresetn, word_not_send, m_send_index == '0, "stray index")

    // Only ack verdicts carry a verdict code.
    `SRSW_ASSERT_NOW(a_verdict_zero, aclk, aresetn, word_not_ack, m_ack_verdict == '0, "stray verdict")

    // Ack, timeout and nothing-to-send words are always the single word of their item.
    `SRSW_ASSERT_NOW(a_single_last, aclk, aresetn, word_not_send, m_last, "lone word without last")

endmodule

bind selective_repeat_sender_window_top srsw_checker u_srsw_checker (.*);
